FILE: rtl/core/rkde_pkg.sv
// Package for the signal strength distance estimator: types, constants and
// the power-of-two fraction table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rkde_pkg;

  localparam int unsigned ExpTableBits = 6;
  localparam int unsigned TabSize      = 1 << ExpTableBits;

  localparam logic [14:0] DistMin = 15'd102;
  localparam logic [14:0] DistMax = 15'd30720;

  // Register indexes
  localparam logic [2:0] RegRssiQ  = 3'd0;
  localparam logic [2:0] RegRssiR  = 3'd1;
  localparam logic [2:0] RegDistQ  = 3'd2;
  localparam logic [2:0] RegDistR  = 3'd3;
  localparam logic [2:0] RegSlope  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RSSI_PRED,
    ST_RSSI_DIV,
    ST_RSSI_MUL,
    ST_RSSI_UPD,
    ST_PATH_MUL,
    ST_PATH_EXP,
    ST_DIST_PRED,
    ST_DIST_DIV,
    ST_DIST_MUL,
    ST_DIST_UPD,
    ST_OUT
  } rkde_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture sample
    logic recal;      // copy estimate into reference power
    logic pred;       // predict covariance for current filter
    logic div_start;  // launch gain division
    logic mul;        // form gain products
    logic upd;        // write back estimate and covariance
    logic path_mul;   // form exponent
    logic path_exp;   // table lookup and shift
    logic sel_dist;   // 1: distance filter
    logic out_load;   // load output register
  } rkde_cmd_t;

  typedef struct packed {
    logic div_done;
  } rkde_sts_t;

  typedef logic [TabSize-1:0][31:0] pow_tab_t;

  // Floor integer square root of a 64-bit word
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bitv;
    res  = '0;
    rem  = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != '0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(i/TabSize) in Q2.30, built from a chain of square roots of two
  function automatic pow_tab_t build_pow_tab();
    logic [10:0][63:0] roots;
    pow_tab_t          tab;
    logic [63:0]       acc;
    int unsigned       h;
    roots    = '0;
    tab      = '0;
    roots[0] = 64'd2 << 30;
    roots[1] = isqrt64(64'd2 << 60);
    for (int unsigned j = 2; j <= 10; j++) roots[j] = isqrt64(roots[j-1] << 30);
    tab[0] = 32'd1 << 30;
    for (int unsigned i = 1; i < TabSize; i++) begin
      h = 0;
      while ((i >> (h + 1)) != 0) h++;
      acc    = 64'(tab[i - (1 << h)]) * roots[ExpTableBits - h] + (64'd1 << 29);
      tab[i] = acc[61:30];
    end
    return tab;
  endfunction

  localparam pow_tab_t PowTab = build_pow_tab();

  // Fraction table lookup
  function automatic logic [31:0] pow_tab(input logic [ExpTableBits-1:0] i);
    return PowTab[i];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rkde_div.sv
// Restoring divider, one quotient bit a cycle: 32-bit dividend over 18-bit
// divisor, 17-bit quotient. Depends on rkde_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rkde_div
  import rkde_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] num_i,
  input  wire logic [17:0] den_i,
  output logic             done_o,
  output logic [16:0]      quo_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [18:0] rem_q, rem_d;
  logic [32:0] sh_q, sh_d;   // dividend bits shifting out, quotient in
  logic [17:0] den_q, den_d;
  logic [18:0] trial;

  assign trial = {rem_q[17:0], sh_q[32]};

  // Shift one dividend bit in and subtract where it fits
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = '0;
      sh_d   = {num_i, 16'd0, 1'b0};
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        sh_d  = {sh_q[31:0], 1'b1};
      end else begin
        rem_d = trial;
        sh_d  = {sh_q[31:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_o = 1'b1;
        rem_d  = rem_q;
        sh_d   = sh_q;
      end
    end
  end

  assign quo_o = (den_q == '0) ? 17'd0 : sh_q[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

FILE: rtl/core/rkde_datapath.sv
// Datapath: filter state, configuration registers, Kalman arithmetic and
// path-loss exponent. Depends on rkde_pkg and rkde_div.
`timescale 1ns / 1ps
`default_nettype none
module rkde_datapath
  import rkde_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rkde_cmd_t   cmd_i,
  output rkde_sts_t        sts_o,
  input  wire logic [7:0]  rssi_dbm_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic [15:0]      smooth_rssi_o,
  output logic [14:0]      distance_o
);
  logic [15:0] rq_q, rr_q, dq_q, dr_q, slope_q;
  logic signed [15:0] rx_q, dx_q, ref_q;
  logic [15:0] rp_q, dp_q;
  logic signed [16:0] z_q;
  logic [15:0] p1_q;
  logic [16:0] k_q;
  logic signed [35:0] prod_q;
  logic [33:0] pprod_q;
  logic signed [40:0] t_q;
  logic [15:0] smooth_q;

  logic [16:0] p1_sum;
  logic [16:0] qsel, rsel;
  logic signed [16:0] xsel;
  logic [15:0] psel;
  logic [16:0] quo;
  logic        div_done;
  logic [35:0] mag;
  logic [19:0] rnd;
  logic signed [16:0] xnew;
  logic [17:0] pnew;
  logic signed [17:0] dpow;
  logic [4:0]  n;
  logic [62:0] dwide;
  logic [32:0] draw;
  logic [14:0] dclamp;

  assign qsel = {1'b0, cmd_i.sel_dist ? dq_q : rq_q};
  assign rsel = {1'b0, cmd_i.sel_dist ? dr_q : rr_q};
  assign xsel = cmd_i.sel_dist ? 17'(dx_q) : 17'(rx_q);
  assign psel = cmd_i.sel_dist ? dp_q : rp_q;
  assign p1_sum = {1'b0, psel} + qsel;

  rkde_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (p1_q),
    .den_i  ({2'b0, p1_q} + {1'b0, rsel}),
    .done_o (div_done),
    .quo_o  (quo)
  );
  assign sts_o.div_done = div_done;

  // Round the gain product half away from zero
  assign mag  = prod_q[35] ? 36'(-prod_q) : 36'(prod_q);
  assign rnd  = 20'((mag + 36'd32768) >> 16);
  assign xnew = prod_q[35] ? xsel - 17'(rnd) : xsel + 17'(rnd);
  assign pnew = 18'((pprod_q + 34'd32768) >> 16);

  // Power of two from the exponent word
  assign dpow  = 18'(ref_q) - 18'(signed'(smooth_q));
  assign n     = t_q[28:24];
  assign dwide = 63'({pow_tab(t_q[23:24-ExpTableBits]), 31'd0} >> (5'd31 - n));
  assign draw  = 33'((dwide + (63'd1 << 29)) >> 30);
  always_comb begin
    if (smooth_q[15] == 1'b0 || t_q < 0) dclamp = DistMin;
    else if (t_q >= 41'sd251658240) dclamp = DistMax;
    else if (draw < 33'(DistMin)) dclamp = DistMin;
    else if (draw > 33'(DistMax)) dclamp = DistMax;
    else dclamp = draw[14:0];
  end

  // Configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_q    <= 16'd82;
      rr_q    <= 16'd16384;
      dq_q    <= 16'd41;
      dr_q    <= 16'd1229;
      slope_q <= 16'd9071;
      rx_q    <= -16'sd15360;
      rp_q    <= 16'd4096;
      dx_q    <= 16'sd1024;
      dp_q    <= 16'd4096;
      ref_q   <= -16'sd14080;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRssiQ: rq_q    <= cfg_data_i;
          RegRssiR: rr_q    <= cfg_data_i;
          RegDistQ: dq_q    <= cfg_data_i;
          RegDistR: dr_q    <= cfg_data_i;
          RegSlope: slope_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.recal) ref_q <= rx_q;
      if (cmd_i.upd) begin
        if (cmd_i.sel_dist) begin
          dx_q <= xnew[15:0];
          dp_q <= pnew[15:0];
        end else begin
          rx_q <= xnew[15:0];
          rp_q <= pnew[15:0];
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) z_q <= 17'(signed'(rssi_dbm_i)) <<< 8;
    if (cmd_i.pred) p1_q <= p1_sum[16] ? 16'hFFFF : p1_sum[15:0];
    if (div_done) k_q <= quo;
    if (cmd_i.mul) begin
      prod_q  <= signed'({19'd0, k_q}) * (36'(z_q) - 36'(xsel));
      pprod_q <= 34'(17'h10000 - k_q) * 34'(p1_q);
    end
    if (cmd_i.upd && !cmd_i.sel_dist) smooth_q <= xnew[15:0];
    if (cmd_i.path_mul) t_q <= 41'(dpow) * signed'({25'd0, slope_q}) + 41'sd167772160;
    if (cmd_i.path_exp) z_q <= 17'(dclamp);
    if (cmd_i.out_load) begin
      smooth_rssi_o <= smooth_q;
      distance_o    <= xnew[14:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rkde_ctrl.sv
// Controller state machine sequencing both filters and the path-loss step.
// Depends on rkde_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rkde_ctrl
  import rkde_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      mode_i,
  input  wire logic      zero_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output rkde_cmd_t      cmd_o,
  input  wire rkde_sts_t sts_i
);
  rkde_state_e state_q, state_d;
  logic        ov_q, ov_d;
  logic        acc;
  logic        start_q;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (acc && !mode_i && !zero_i) state_d = ST_RSSI_PRED;
      ST_RSSI_PRED: state_d = ST_RSSI_DIV;
      ST_RSSI_DIV:  if (sts_i.div_done) state_d = ST_RSSI_MUL;
      ST_RSSI_MUL:  state_d = ST_RSSI_UPD;
      ST_RSSI_UPD:  state_d = ST_PATH_MUL;
      ST_PATH_MUL:  state_d = ST_PATH_EXP;
      ST_PATH_EXP:  state_d = ST_DIST_PRED;
      ST_DIST_PRED: state_d = ST_DIST_DIV;
      ST_DIST_DIV:  if (sts_i.div_done) state_d = ST_DIST_MUL;
      ST_DIST_MUL:  state_d = ST_DIST_UPD;
      ST_DIST_UPD:  state_d = (ov_q && !out_ready_i) ? ST_OUT : ST_IDLE;
      ST_OUT:       if (!ov_q || out_ready_i) state_d = ST_DIST_UPD;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Commands; launch the divider on the first cycle of each division state
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load  = acc && !mode_i;
        cmd_o.recal = acc && mode_i;
      end
      ST_RSSI_PRED: begin
        cmd_o.pred = 1'b1;
      end
      ST_RSSI_DIV: cmd_o.div_start = start_q;
      ST_RSSI_MUL: cmd_o.mul = 1'b1;
      ST_RSSI_UPD: cmd_o.upd = 1'b1;
      ST_PATH_MUL: cmd_o.path_mul = 1'b1;
      ST_PATH_EXP: cmd_o.path_exp = 1'b1;
      ST_DIST_PRED: begin
        cmd_o.pred     = 1'b1;
        cmd_o.sel_dist = 1'b1;
      end
      ST_DIST_DIV: begin
        cmd_o.sel_dist  = 1'b1;
        cmd_o.div_start = start_q;
      end
      ST_DIST_MUL: begin
        cmd_o.mul      = 1'b1;
        cmd_o.sel_dist = 1'b1;
      end
      ST_DIST_UPD: begin
        cmd_o.sel_dist = 1'b1;
        cmd_o.upd      = !ov_q || out_ready_i;
        cmd_o.out_load = !ov_q || out_ready_i;
      end
      ST_OUT: cmd_o.sel_dist = 1'b1;
      default: ;
    endcase
  end

  // Output valid
  always_comb begin
    ov_d = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (state_q == ST_DIST_UPD && (!ov_q || out_ready_i)) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      start_q <= (state_q == ST_RSSI_PRED || state_q == ST_DIST_PRED);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rssi_kalman_distance_estimator_unit.sv
// Distance estimator from received signal strength: a strength Kalman filter,
// a log-distance path-loss map and a distance Kalman filter, one sample at a
// time, each sample spending most of its time in two bit-serial gain
// divisions. The next sample is accepted only once the result is registered
// and the controller is back in its idle state, so a new sample is never
// taken before the last one is through. A result still waiting in the output
// register holds the last step. Recalibrate and zero samples give no result.
// Depends on rkde_pkg, rkde_ctrl, rkde_datapath.
`timescale 1ns / 1ps
`default_nettype none
module rssi_kalman_distance_estimator_unit
  import rkde_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  rssi_dbm_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      smooth_rssi_o,
  output logic [14:0]      distance_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  rkde_cmd_t cmd;
  rkde_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rkde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .zero_i     (rssi_dbm_i == 8'd0),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rkde_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rssi_dbm_i   (rssi_dbm_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_idx_i    (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .smooth_rssi_o(smooth_rssi_o),
    .distance_o   (distance_o)
  );
endmodule
`default_nettype wire

FILE: sim/tb_rssi_kalman_distance_estimator_unit.sv
// Testbench for rssi_kalman_distance_estimator_unit: directed and random
// samples, checked against an in-bench fixed-point filter model.
// Depends on rkde_pkg and the RTL of the unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_rssi_kalman_distance_estimator_unit;
  import rkde_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned SettleCycles = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [7:0]  rssi_dbm_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] smooth_rssi_o;
  logic [14:0] distance_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  typedef struct packed {
    logic [15:0] smooth;
    logic [14:0] metres;
  } estimate_t;

  estimate_t estimate_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          steady = 1'b0;

  // Filter model state and registers
  longint unsigned q_rssi, r_rssi, q_dist, r_dist, slope;
  longint          x_rssi, x_dist, ref_pwr;
  longint unsigned p_rssi, p_dist;
  longint unsigned frac_tab [0:TabSize-1];

  rssi_kalman_distance_estimator_unit i_dut (.*);

  always #6 clk_i = ~clk_i;

  // Hold off the result side at random, except in steady stretches
  always @(posedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(0, 99) >= 24);
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Reset values and the power-of-two fraction table
  task automatic model_reset();
    longint unsigned roots [0:10];
    int unsigned h;
    q_rssi = 82; r_rssi = 16384; q_dist = 41; r_dist = 1229; slope = 9071;
    x_rssi = -15360; p_rssi = 4096; x_dist = 1024; p_dist = 4096;
    ref_pwr = -14080;
    roots[0] = 64'd2 << 30;
    roots[1] = int_sqrt(64'd2 << 60);
    for (int i = 2; i <= 10; i++) roots[i] = int_sqrt(roots[i-1] << 30);
    frac_tab[0] = 64'd1 << 30;
    for (int unsigned i = 1; i < TabSize; i++) begin
      h = 0;
      while ((i >> (h + 1)) != 0) h++;
      frac_tab[i] = (frac_tab[i - (1 << h)] * roots[(ExpTableBits - h) % 11]
                     + (64'd1 << 29)) >> 30;
    end
  endtask

  task automatic kalman_update(inout longint x, inout longint unsigned p,
                               input longint unsigned q, input longint unsigned r,
                               input longint z);
    longint unsigned p1, k, mag;
    longint prod;
    p1 = p + q;
    if (p1 > 65535) p1 = 65535;
    k = (p1 + r != 0) ? (p1 << 16) / (p1 + r) : 0;
    prod = longint'(k) * (z - x);
    mag = (prod < 0) ? longint'(-prod) : prod;
    x = (prod < 0) ? x - longint'((mag + 32768) >> 16)
                   : x + longint'((mag + 32768) >> 16);
    p = ((65536 - k) * p1 + 32768) >> 16;
  endtask

  function automatic longint path_metres(input longint smooth);
    longint t;
    longint unsigned d;
    int unsigned n, idx;
    if (smooth >= 0) return DistMin;
    t = (ref_pwr - smooth) * longint'(slope) + (longint'(10) << 24);
    if (t < 0) return DistMin;
    if (t >= (longint'(15) << 24)) return DistMax;
    n = 32'(t >> 24);
    idx = 32'((t >> (24 - ExpTableBits)) & (TabSize - 1));
    d = ((frac_tab[idx] << n) + (64'd1 << 29)) >> 30;
    if (d < DistMin) d = DistMin;
    if (d > DistMax) d = DistMax;
    return d;
  endfunction

  // Advance the model by one accepted transaction
  task automatic predict_estimate(input bit recal, input logic [7:0] dbm);
    estimate_t e;
    if (recal) begin
      ref_pwr = x_rssi;
    end else if (dbm != 0) begin
      kalman_update(x_rssi, p_rssi, q_rssi, r_rssi, longint'($signed(dbm)) * 256);
      kalman_update(x_dist, p_dist, q_dist, r_dist, path_metres(x_rssi));
      e.smooth = x_rssi[15:0];
      e.metres = x_dist[14:0];
      estimate_q.push_back(e);
    end
  endtask

  task automatic send_sample(input bit recal, input logic [7:0] dbm);
    if (!steady && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= recal;
    rssi_dbm_i <= dbm;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_estimate(recal, dbm);
  endtask

  // Let the unit drain, then write one register
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    in_valid_i <= 1'b0;
    wait (estimate_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegRssiQ: q_rssi = val;
      RegRssiR: r_rssi = val;
      RegDistQ: q_dist = val;
      RegDistR: r_dist = val;
      RegSlope: slope = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] qr, rr, qd, rd, sl);
    write_reg(RegRssiQ, qr);
    write_reg(RegRssiR, rr);
    write_reg(RegDistQ, qd);
    write_reg(RegDistR, rd);
    write_reg(RegSlope, sl);
  endtask

  // Field extremes, zero samples, recalibration and strong positive samples
  task automatic test_directed();
    logic [7:0] pattern [10] = '{8'h80, 8'h7f, 8'hff, 8'h01, 8'h00, 8'hc4,
                                 8'haa, 8'h55, 8'h9c, 8'hd8};
    foreach (pattern[i]) send_sample(1'b0, pattern[i]);
    send_sample(1'b1, 8'h5a);
    send_sample(1'b0, 8'hb0);
    send_sample(1'b1, 8'ha5);
    // drive the smoothed strength non-negative
    repeat (10) send_sample(1'b0, 8'h7f);
    send_sample(1'b0, 8'h80);
  endtask

  // Register extremes: zero gain denominator, zero slope, saturating exponent
  task automatic test_register_extremes();
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (8) send_sample(1'b0, 8'($urandom_range(0, 255)) | 8'h80);
    write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    repeat (6) send_sample(1'b0, 8'h80);
    send_sample(1'b1, 8'h00);
    repeat (6) send_sample(1'b0, 8'h7f);
    // out-of-range indexes must be ignored
    for (int i = RegSlope + 1; i < 8; i++) write_reg(3'(i), 16'h1234);
    repeat (4) send_sample(1'b0, 8'hc0);
    write_all(16'd82, 16'd16384, 16'd41, 16'd1229, 16'd1);
    repeat (4) send_sample(1'b0, 8'hb5);
  endtask

  // Random phases, every third with the reset settings and the rest with random settings; one phase with no idling
  task automatic test_random(input int unsigned total);
    int unsigned phase_len, sent, sel;
    logic [7:0] dbm;
    sent = 0;
    for (int ph = 0; sent < total; ph++) begin
      if (ph % 3 == 0) begin
        write_all(16'd82, 16'd16384, 16'd41, 16'd1229, 16'd9071);
      end else begin
        write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(1, 65535)));
        write_reg(RegSlope, (ph % 4 == 1) ? 16'($urandom_range(4000, 20000))
                                          : 16'($urandom));
        write_reg(RegRssiQ, 16'($urandom_range(0, 400)));
      end
      steady = (ph == 2);
      phase_len = $urandom_range(60, 160);
      for (int unsigned i = 0; i < phase_len && sent < total; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) dbm = 8'(-$urandom_range(30, 100));
        else dbm = 8'($urandom);
        if (sel >= 97) dbm = 8'h00;
        send_sample(sel >= 94 && sel < 97, dbm);
        sent++;
      end
      steady = 1'b0;
    end
  endtask

  // Compare each result transaction with the oldest expected estimate
  always @(negedge clk_i) begin
    estimate_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (estimate_q.size() == 0) begin
        $display("%0t: unexpected result smooth=%0d distance=%0d", $time,
                 $signed(smooth_rssi_o), distance_o);
        mismatches++;
      end else begin
        e = estimate_q.pop_front();
        if (smooth_rssi_o !== e.smooth) begin
          $display("%0t: smooth_rssi expected %0d actual %0d", $time,
                   $signed(e.smooth), $signed(smooth_rssi_o));
          mismatches++;
        end
        if (distance_o !== e.metres) begin
          $display("%0t: distance expected %0d actual %0d", $time, e.metres,
                   distance_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel
  initial begin
    while (idle_cycles < IdleLimit) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random(1150);
    in_valid_i <= 1'b0;
    wait (estimate_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && estimate_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
